/* design/rmcs_pkg.sv */
// Package: sizes, codes and state types for the rate-monotonic scheduler
`timescale 1ns / 1ps
package rmcs_pkg;
    localparam int NUM_TASKS = 16;
    localparam int CPU_COUNT = 4;
    localparam int TASK_W    = $clog2(NUM_TASKS);
    localparam int CPU_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int CNT_W     = TASK_W + 1;
    localparam int TIME_W    = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_READY = 2'd1,
        ST_RUN   = 2'd2,
        ST_DONE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_SCAN,
        S_PLACE,
        S_EXEC,
        S_SUM,
        S_OUT
    } state_t;
endpackage

/* design/rmcs_req_if.sv */
// Interfaces: request, result and configuration channels
`timescale 1ns / 1ps
interface rmcs_req_if import rmcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [TASK_W-1:0] task_index;
    logic [TIME_W-1:0] arrive_tick;
    logic [TIME_W-1:0] burst_length;
    logic [TIME_W-1:0] task_period;
    modport source (output valid, command, task_index, arrive_tick, burst_length,
                    task_period, input ready);
    modport sink (input valid, command, task_index, arrive_tick, burst_length,
                  task_period, output ready);
endinterface

interface rmcs_rsp_if import rmcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CPU_W-1:0]  cpu_index;
    logic              cpu_busy;
    logic [TASK_W-1:0] running_task;
    logic              task_done;
    logic [TIME_W-1:0] tick_time;
    logic              all_done;
    logic              last_result;
    modport source (output valid, cpu_index, cpu_busy, running_task, task_done, tick_time,
                    all_done, last_result, input ready);
    modport sink (input valid, cpu_index, cpu_busy, running_task, task_done, tick_time,
                  all_done, last_result, output ready);
endinterface

interface rmcs_cfg_if import rmcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* design/rate_monotonic_multicpu_scheduler.sv */
// Top level: multi-CPU rate-monotonic scheduler with a sequenced task-table scan
`timescale 1ns / 1ps
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, task_index, arrive_tick, burst_length, task_period
//  rsp     | out | valid/ready | cpu_index, cpu_busy, running_task, task_done, tick_time,
//          |     |             | all_done, last_result
//  cfg     | in  | valid/ready | data = task_count
//
//  A load is applied in the idle state. A tick runs a drop step, up to CPU_COUNT+1 selection
//  passes (each a scan of all NUM_TASKS table entries, then a place step), an execute step
//  per CPU, a summary step and one result per CPU; the table scan examines one entry per
//  cycle. req is ready only when idle; results hold under stall.
//  Reset clears time, task_count and all CPU assignments; the task table is not cleared.
module rate_monotonic_multicpu_scheduler import rmcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rmcs_req_if.sink    req,
    rmcs_rsp_if.source  rsp,
    rmcs_cfg_if.sink    cfg
);
    state_t state_reg, state_next;

    status_t           status_reg  [NUM_TASKS];
    logic [TIME_W-1:0] arrival_reg [NUM_TASKS];
    logic [TIME_W-1:0] period_reg  [NUM_TASKS];
    logic [TIME_W-1:0] remain_reg  [NUM_TASKS];

    logic              cpu_valid_reg [CPU_COUNT];
    logic [TASK_W-1:0] cpu_task_reg  [CPU_COUNT];
    logic [TIME_W-1:0] cpu_per_reg   [CPU_COUNT];
    logic              ran_reg       [CPU_COUNT];
    logic [TASK_W-1:0] ran_task_reg  [CPU_COUNT];
    logic              done_reg      [CPU_COUNT];

    logic [TIME_W-1:0] time_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TASK_W-1:0] scan_idx_reg;
    logic [CPU_W-1:0]  cpu_cnt_reg;
    logic              found_reg;
    logic [TASK_W-1:0] best_idx_reg;
    logic [TIME_W-1:0] best_per_reg;
    logic              all_done_reg;

    logic [CNT_W-1:0]  used_n;
    logic              scan_elig;
    logic              scan_better;
    logic              scan_last;
    logic              cpu_last;
    logic              idle_found;
    logic [CPU_W-1:0]  idle_cpu;
    logic [CPU_W-1:0]  max_cpu;
    logic [TIME_W-1:0] max_per;
    logic              place_ok;
    logic [TASK_W-1:0] exec_task;
    logic [TIME_W-1:0] exec_rem;
    logic              all_comb;
    logic              req_fire;
    logic              rsp_fire;

    assign used_n    = (count_reg > CNT_W'(NUM_TASKS)) ? CNT_W'(NUM_TASKS) : count_reg;
    assign scan_elig = ({1'b0, scan_idx_reg} < used_n) && (status_reg[scan_idx_reg] == ST_READY)
                       && (arrival_reg[scan_idx_reg] <= time_reg);
    // strict compare keeps the lower index on equal periods
    assign scan_better = scan_elig && (!found_reg || period_reg[scan_idx_reg] < best_per_reg);
    assign scan_last   = (scan_idx_reg == TASK_W'(NUM_TASKS - 1));
    assign cpu_last    = (cpu_cnt_reg == CPU_W'(CPU_COUNT - 1));
    assign exec_task   = cpu_task_reg[cpu_cnt_reg];
    assign exec_rem    = remain_reg[exec_task];
    assign req_fire    = req.valid && req.ready;
    assign rsp_fire    = rsp.valid && rsp.ready;

    // first idle CPU, else the longest-period CPU (lowest on ties)
    always_comb
    begin
        idle_found = 1'b0;
        idle_cpu   = '0;
        max_cpu    = '0;
        max_per    = cpu_per_reg[0];
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            if (!idle_found && !cpu_valid_reg[c])
            begin
                idle_found = 1'b1;
                idle_cpu   = CPU_W'(c);
            end
            if (cpu_per_reg[c] > max_per)
            begin
                max_per = cpu_per_reg[c];
                max_cpu = CPU_W'(c);
            end
        end
    end

    assign place_ok = found_reg && (idle_found || best_per_reg < max_per);

    always_comb
    begin
        all_comb = 1'b1;
        for (int p = 0; p < NUM_TASKS; p++)
        begin
            if ((CNT_W'(p) < used_n) && (status_reg[p] != ST_DONE))
            begin
                all_comb = 1'b0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.command == CMD_TICK)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = place_ok ? S_SCAN : S_EXEC;
            S_EXEC:
            begin
                if (cpu_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:   state_next = S_OUT;
            S_OUT:
            begin
                if (rsp_fire && cpu_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        case (state_reg)
            S_IDLE:  req.ready = 1'b1;
            S_OUT:   rsp.valid = 1'b1;
            default:
            begin
                req.ready = 1'b0;
                rsp.valid = 1'b0;
            end
        endcase
    end

    assign cfg.ready        = 1'b1;
    assign rsp.cpu_index    = cpu_cnt_reg;
    assign rsp.cpu_busy     = ran_reg[cpu_cnt_reg];
    assign rsp.running_task = ran_task_reg[cpu_cnt_reg];
    assign rsp.task_done    = done_reg[cpu_cnt_reg];
    assign rsp.tick_time    = time_reg;
    assign rsp.all_done     = all_done_reg;
    assign rsp.last_result  = cpu_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            time_reg    <= '0;
            count_reg   <= '0;
            scan_idx_reg <= '0;
            cpu_cnt_reg <= '0;
            found_reg   <= 1'b0;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                cpu_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    scan_idx_reg <= '0;
                    found_reg    <= 1'b0;
                    cpu_cnt_reg  <= '0;
                    if (req_fire && req.command == CMD_LOAD)
                    begin
                        for (int c = 0; c < CPU_COUNT; c++)
                        begin
                            if (cpu_valid_reg[c] && cpu_task_reg[c] == req.task_index)
                            begin
                                cpu_valid_reg[c] <= 1'b0;
                            end
                        end
                    end
                end
                S_DROP:
                begin
                    for (int c = 0; c < CPU_COUNT; c++)
                    begin
                        if (cpu_valid_reg[c] && ({1'b0, cpu_task_reg[c]} >= used_n))
                        begin
                            cpu_valid_reg[c] <= 1'b0;
                        end
                    end
                end
                S_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_PLACE:
                begin
                    found_reg    <= 1'b0;
                    scan_idx_reg <= '0;
                    cpu_cnt_reg  <= '0;
                    if (place_ok)
                    begin
                        cpu_valid_reg[idle_found ? idle_cpu : max_cpu] <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    cpu_cnt_reg <= cpu_cnt_reg + 1'b1;
                    if (cpu_valid_reg[cpu_cnt_reg] && exec_rem <= TIME_W'(1))
                    begin
                        cpu_valid_reg[cpu_cnt_reg] <= 1'b0;
                    end
                end
                S_SUM:   cpu_cnt_reg <= '0;
                S_OUT:
                begin
                    if (rsp_fire)
                    begin
                        cpu_cnt_reg <= cpu_cnt_reg + 1'b1;
                        if (cpu_last && time_reg != {TIME_W{1'b1}})
                        begin
                            time_reg <= time_reg + 1'b1;
                        end
                    end
                end
                default: cpu_cnt_reg <= '0;
            endcase
        end
    end

    // task table and per-CPU payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.command == CMD_LOAD)
                begin
                    arrival_reg[req.task_index] <= req.arrive_tick;
                    remain_reg[req.task_index]  <= req.burst_length;
                    period_reg[req.task_index]  <= req.task_period;
                    status_reg[req.task_index]  <= ST_READY;
                end
            end
            S_DROP:
            begin
                for (int c = 0; c < CPU_COUNT; c++)
                begin
                    if (cpu_valid_reg[c] && ({1'b0, cpu_task_reg[c]} >= used_n))
                    begin
                        status_reg[cpu_task_reg[c]] <= ST_READY;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_better)
                begin
                    best_idx_reg <= scan_idx_reg;
                    best_per_reg <= period_reg[scan_idx_reg];
                end
            end
            S_PLACE:
            begin
                if (place_ok)
                begin
                    // a preempted task goes back to ready
                    if (!idle_found)
                    begin
                        status_reg[cpu_task_reg[max_cpu]] <= ST_READY;
                    end
                    status_reg[best_idx_reg] <= ST_RUN;
                    cpu_task_reg[idle_found ? idle_cpu : max_cpu] <= best_idx_reg;
                    cpu_per_reg[idle_found ? idle_cpu : max_cpu]  <= best_per_reg;
                end
            end
            S_EXEC:
            begin
                ran_reg[cpu_cnt_reg]      <= cpu_valid_reg[cpu_cnt_reg];
                ran_task_reg[cpu_cnt_reg] <= cpu_valid_reg[cpu_cnt_reg] ? exec_task : '0;
                done_reg[cpu_cnt_reg]     <= cpu_valid_reg[cpu_cnt_reg]
                                             && (exec_rem <= TIME_W'(1));
                if (cpu_valid_reg[cpu_cnt_reg])
                begin
                    if (exec_rem <= TIME_W'(1))
                    begin
                        remain_reg[exec_task] <= '0;
                        status_reg[exec_task] <= ST_DONE;
                    end
                    else
                    begin
                        remain_reg[exec_task] <= exec_rem - 1'b1;
                    end
                end
            end
            S_SUM:   all_done_reg <= all_comb;
            default: all_done_reg <= all_done_reg;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.last_result) |=> req.ready)
        else $error("scheduler not idle after last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_TICK) |=> !req.ready && !rsp.valid)
        else $error("tick did not start processing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.cpu_busy) |-> (rsp.running_task == '0 && !rsp.task_done))
        else $error("idle CPU result carries a task");
endmodule

/* tb/sv/rate_monotonic_multicpu_scheduler_tb.sv */
// Testbench: random and directed loads and ticks checked against an in-bench scheduler model
`timescale 1ns / 1ps
module rate_monotonic_multicpu_scheduler_tb;
    import rmcs_pkg::*;

    typedef struct {
        logic              command;
        logic [TASK_W-1:0] task_index;
        logic [TIME_W-1:0] arrive_tick;
        logic [TIME_W-1:0] burst_length;
        logic [TIME_W-1:0] task_period;
    } sched_item_t;

    typedef struct {
        logic [CPU_W-1:0]  cpu_index;
        logic              cpu_busy;
        logic [TASK_W-1:0] running_task;
        logic              task_done;
        logic [TIME_W-1:0] tick_time;
        logic              all_done;
        logic              last_result;
    } cpu_report_t;

    logic clk;
    logic rst_n;

    rmcs_req_if req ();
    rmcs_rsp_if rsp ();
    rmcs_cfg_if cfg ();

    rate_monotonic_multicpu_scheduler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    sched_item_t pending_items[$];
    cpu_report_t expected_reports[$];
    int          fail_count = 0;
    bit          calm = 0;
    int unsigned ticks_queued = 0;

    // scheduler state mirror
    status_t           tbl_status[NUM_TASKS];
    logic [TIME_W-1:0] tbl_arrival[NUM_TASKS];
    logic [TIME_W-1:0] tbl_period[NUM_TASKS];
    logic [TIME_W-1:0] tbl_remaining[NUM_TASKS];
    logic              cpu_held[CPU_COUNT];
    logic [TASK_W-1:0] cpu_task[CPU_COUNT];
    logic [TIME_W-1:0] sched_now = '0;
    int unsigned       tasks_in_use = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            cpu_held[c] = 1'b0;
            cpu_task[c] = '0;
        end
        for (int t = 0; t < NUM_TASKS; t++)
            tbl_status[t] = ST_EMPTY;
    end

    function automatic void assign_cpu(int c, int t);
        cpu_held[c] = 1'b1;
        cpu_task[c] = t[TASK_W-1:0];
        tbl_status[t] = ST_RUN;
    endfunction

    function automatic void schedule_tick_or_load(sched_item_t it);
        int          n;
        int          cnt;
        int          order[NUM_TASKS];
        int          key;
        int          b;
        int          cand;
        int          target;
        bit          idle;
        bit          have;
        int          best;
        bit          found;
        bit          all;
        cpu_report_t r[CPU_COUNT];
        n = (tasks_in_use > NUM_TASKS) ? NUM_TASKS : tasks_in_use;
        cnt = 0;
        all = 1;
        if (it.command == CMD_LOAD)
        begin
            for (int c = 0; c < CPU_COUNT; c++)
                if (cpu_held[c] && cpu_task[c] == it.task_index)
                    cpu_held[c] = 1'b0;
            tbl_arrival[it.task_index]   = it.arrive_tick;
            tbl_remaining[it.task_index] = it.burst_length;
            tbl_period[it.task_index]    = it.task_period;
            tbl_status[it.task_index]    = ST_READY;
            return;
        end
        // tasks dropped from use release their CPU
        for (int c = 0; c < CPU_COUNT; c++)
            if (cpu_held[c] && cpu_task[c] >= n)
            begin
                tbl_status[cpu_task[c]] = ST_READY;
                cpu_held[c] = 1'b0;
            end
        for (int p = 0; p < n; p++)
            if (tbl_status[p] == ST_READY && tbl_arrival[p] <= sched_now)
                order[cnt++] = p;
        for (int a = 1; a < cnt; a++)
        begin
            key = order[a];
            b = a;
            while (b > 0 && tbl_period[order[b-1]] > tbl_period[key])
            begin
                order[b] = order[b-1];
                b--;
            end
            order[b] = key;
        end
        for (int i = 0; i < cnt; i++)
        begin
            cand = order[i];
            target = 0;
            idle = 0;
            have = 0;
            if (tbl_status[cand] != ST_READY)
                continue;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                if (!cpu_held[c])
                begin
                    target = c;
                    idle = 1;
                    break;
                end
                if (!have || tbl_period[cpu_task[c]] > tbl_period[cpu_task[target]])
                begin
                    target = c;
                    have = 1;
                end
            end
            if (idle)
                assign_cpu(target, cand);
            else if (have && tbl_period[cand] < tbl_period[cpu_task[target]])
            begin
                tbl_status[cpu_task[target]] = ST_READY;
                assign_cpu(target, cand);
            end
        end
        for (int c = 0; c < CPU_COUNT; c++)
            if (!cpu_held[c])
            begin
                found = 0;
                best = 0;
                for (int p = 0; p < n; p++)
                    if (tbl_status[p] == ST_READY && tbl_arrival[p] <= sched_now &&
                        (!found || tbl_period[p] < tbl_period[best]))
                    begin
                        best = p;
                        found = 1;
                    end
                if (found)
                    assign_cpu(c, best);
            end
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            r[c].cpu_index    = c[CPU_W-1:0];
            r[c].cpu_busy     = cpu_held[c];
            r[c].running_task = cpu_held[c] ? cpu_task[c] : '0;
            r[c].task_done    = 1'b0;
            r[c].tick_time    = sched_now;
            r[c].last_result  = (c == CPU_COUNT - 1);
            if (cpu_held[c])
            begin
                if (tbl_remaining[cpu_task[c]] <= 1)
                begin
                    tbl_remaining[cpu_task[c]] = '0;
                    tbl_status[cpu_task[c]] = ST_DONE;
                    cpu_held[c] = 1'b0;
                    r[c].task_done = 1'b1;
                end
                else
                    tbl_remaining[cpu_task[c]] = tbl_remaining[cpu_task[c]] - 1'b1;
            end
        end
        for (int p = 0; p < n; p++)
            if (tbl_status[p] != ST_DONE)
                all = 0;
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            r[c].all_done = all;
            expected_reports.push_back(r[c]);
        end
        if (sched_now != 16'hFFFF)
            sched_now = sched_now + 1'b1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid        <= 1'b0;
            req.command      <= CMD_LOAD;
            req.task_index   <= '0;
            req.arrive_tick  <= '0;
            req.burst_length <= '0;
            req.task_period  <= '0;
            rsp.ready        <= 1'b0;
        end
        else
        begin
            rsp.ready <= calm || ($urandom_range(99) >= 11);
            if (!req.valid || req.ready)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 11))
                begin
                    req.valid        <= 1'b1;
                    req.command      <= pending_items[0].command;
                    req.task_index   <= pending_items[0].task_index;
                    req.arrive_tick  <= pending_items[0].arrive_tick;
                    req.burst_length <= pending_items[0].burst_length;
                    req.task_period  <= pending_items[0].task_period;
                    void'(pending_items.pop_front());
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sched_item_t it;
        cpu_report_t e;
        if (rst_n && req.valid && req.ready)
        begin
            it.command      = req.command;
            it.task_index   = req.task_index;
            it.arrive_tick  = req.arrive_tick;
            it.burst_length = req.burst_length;
            it.task_period  = req.task_period;
            schedule_tick_or_load(it);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected item cpu_index=%0d", $time, rsp.cpu_index);
                fail_count++;
            end
            else
            begin
                e = expected_reports.pop_front();
                if (rsp.cpu_index !== e.cpu_index)
                begin
                    $display("%0t: cpu_index exp %0d got %0d", $time, e.cpu_index, rsp.cpu_index);
                    fail_count++;
                end
                if (rsp.cpu_busy !== e.cpu_busy)
                begin
                    $display("%0t: cpu_busy exp %0d got %0d", $time, e.cpu_busy, rsp.cpu_busy);
                    fail_count++;
                end
                if (rsp.running_task !== e.running_task)
                begin
                    $display("%0t: running_task exp %0d got %0d", $time, e.running_task,
                             rsp.running_task);
                    fail_count++;
                end
                if (rsp.task_done !== e.task_done)
                begin
                    $display("%0t: task_done exp %0d got %0d", $time, e.task_done, rsp.task_done);
                    fail_count++;
                end
                if (rsp.tick_time !== e.tick_time)
                begin
                    $display("%0t: tick_time exp %0d got %0d", $time, e.tick_time, rsp.tick_time);
                    fail_count++;
                end
                if (rsp.all_done !== e.all_done)
                begin
                    $display("%0t: all_done exp %0d got %0d", $time, e.all_done, rsp.all_done);
                    fail_count++;
                end
                if (rsp.last_result !== e.last_result)
                begin
                    $display("%0t: last_result exp %0d got %0d", $time, e.last_result,
                             rsp.last_result);
                    fail_count++;
                end
            end
        end
    end

    task automatic add_load(int idx, int arr, int bst, int per);
        sched_item_t it;
        it.command      = CMD_LOAD;
        it.task_index   = idx[TASK_W-1:0];
        it.arrive_tick  = arr[TIME_W-1:0];
        it.burst_length = bst[TIME_W-1:0];
        it.task_period  = per[TIME_W-1:0];
        pending_items.push_back(it);
    endtask

    task automatic add_tick();
        sched_item_t it;
        it.command      = CMD_TICK;
        it.task_index   = $urandom;
        it.arrive_tick  = $urandom;
        it.burst_length = $urandom;
        it.task_period  = $urandom;
        pending_items.push_back(it);
        ticks_queued++;
    endtask

    // drain everything, then let any load still in flight settle
    task automatic wait_quiet();
        while (pending_items.size() > 0 || req.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_task_count(int value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value[CNT_W-1:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        tasks_in_use = value;
        cfg.valid <= 1'b0;
    endtask

    initial begin
        int counts[8];
        int arr;
        int bst;
        int per;
        counts = '{4, 16, 1, 9, 16, 0, 6, 16};
        cfg.valid = 1'b0;
        cfg.data  = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table with count 0, then tick with nothing in use
        write_task_count(0);
        for (int t = 0; t < NUM_TASKS; t++)
            add_load(t, t % 3, 1 + (t % 4), 5 + (t % 3));
        add_load(15, 65535, 65535, 65535);
        add_load(14, 0, 65535, 1);
        add_load(13, 0, 0, 2);
        add_tick();
        wait_quiet();

        // full table: contention, preemption, zero burst, reload of a running task
        write_task_count(16);
        add_tick();
        add_tick();
        add_load(0, 0, 3, 1);
        add_tick();
        add_load(14, 0, 2, 3);
        add_tick();
        add_tick();
        wait_quiet();

        // dropping the count frees CPUs running tasks above it
        write_task_count(2);
        add_tick();
        add_tick();
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            calm = (ph == 4);
            write_task_count(counts[ph]);
            for (int k = 0; k < 18; k++)
            begin
                if ($urandom_range(99) < 45)
                begin
                    arr = ticks_queued + $urandom_range(0, 4) - 1;
                    if (arr < 0)
                        arr = 0;
                    bst = $urandom_range(1, 6);
                    per = $urandom_range(1, 12);
                    if ($urandom_range(9) == 0)
                        arr = $urandom_range(0, 65535);
                    if ($urandom_range(9) == 0)
                        bst = $urandom_range(0, 65535);
                    if ($urandom_range(9) == 0)
                        per = $urandom_range(1, 65535);
                    add_load($urandom_range(0, NUM_TASKS - 1), arr, bst, per);
                end
                else
                    add_tick();
            end
            wait_quiet();
        end
        calm = 0;

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
